[design/htlc_pkg.sv]
// Shared types and constants for the handle table block.
`timescale 1ns / 1ps
`default_nettype none
package htlc_pkg;
  localparam int NumGroups    = 16;
  localparam int Capacity     = 256;
  localparam int MaxBuckets   = 64;
  localparam int CacheEntries = 4;
  localparam int EW = $clog2(Capacity);
  localparam int LW = EW + 1;
  localparam int GW = 4;
  localparam int BW = $clog2(MaxBuckets);
  localparam int HW = $clog2(NumGroups * MaxBuckets);
  localparam logic [LW-1:0] Nil = LW'(Capacity);

  typedef enum logic [2:0] {
    KIND_OPEN = 3'd0, KIND_CLOSE = 3'd1, KIND_REG = 3'd2,
    KIND_LOOKUP = 3'd3, KIND_REMOVE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BAD = 2'd1, ST_MISS = 2'd2, ST_FULL = 2'd3
  } status_e;

  // item passed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic [GW-1:0] group;
    logic [15:0] bucket_count;
    logic [31:0] handle_id;
    logic [31:0] object_value;
  } item_t;
endpackage
`default_nettype wire

[design/htlc_front.sv]
// Front: command intake and a two-entry queue toward the back.
`timescale 1ns / 1ps
`default_nettype none
module htlc_front (
  input  wire  logic           clk_i,
  input  wire  logic           rst_ni,
  input  wire  logic           start_i,
  input  wire  htlc_pkg::item_t item_i,
  output logic                 busy_o,
  output logic                 q_valid_o,
  output htlc_pkg::item_t      q_item_o,
  input  wire  logic           q_pop_i
);
  import htlc_pkg::*;
  item_t slot_q [2];
  logic [1:0] cnt_q;
  logic rd_q;
  logic push;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
    end else begin
      if (push) slot_q[rd_q ^ cnt_q[0]] <= item_i;
      if (q_pop_i && q_valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i && q_valid_o);
    end
  end
endmodule
`default_nettype wire

[design/htlc_back.sv]
// Back: sequencer that carries out table commands over the memories.
`timescale 1ns / 1ps
`default_nettype none
module htlc_back (
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  logic            q_valid_i,
  input  wire  htlc_pkg::item_t q_item_i,
  output logic                  q_pop_o,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [31:0]           new_id_o,
  output logic [31:0]           found_object_o,
  output logic                  cache_hit_o
);
  import htlc_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_HEADRD, S_HEADWT, S_REGWR, S_WALKRD, S_WALKCMP,
    S_RMFREE, S_DROPRD, S_DROPWT, S_DROPNX, S_DROPLK, S_DONE
  } state_e;

  // memories
  logic [LW-1:0] head_mem [NumGroups*MaxBuckets];
  logic [31:0]   eid_mem  [Capacity];
  logic [31:0]   eobj_mem [Capacity];
  logic [LW-1:0] link_mem [Capacity];

  logic [7:0]    use_q  [NumGroups];
  logic [27:0]   seq_q  [NumGroups];
  logic [BW-1:0] mask_q [NumGroups];
  logic [LW-1:0] free_q;
  logic [31:0]   ck_q [CacheEntries];
  logic [31:0]   co_q [CacheEntries];
  logic          cv_q [CacheEntries];

  state_e        st_q;
  item_t         it_q;
  logic [HW:0]   ctr_q;      // init sweep / bucket index
  logic [HW-1:0] hidx_q;
  logic [LW-1:0] cur_q, prev_q;
  logic [LW:0]   steps_q;
  logic [31:0]   rid_q, robj_q;
  logic [LW-1:0] rhead_q, rlink_q;
  logic [1:0]    stat_q;
  logic [31:0]   nid_q, fobj_q;
  logic          hit_q;

  logic [GW-1:0] idg;
  logic [2:0]    ck_hit;
  logic          c_any;
  logic [15:0]   bcm1;
  logic [HW-1:0] sidx;

  assign idg  = it_q.handle_id[31:28];
  assign bcm1 = it_q.bucket_count - 16'd1;
  assign sidx = {it_q.group, BW'(seq_q[it_q.group]) & mask_q[it_q.group]};

  always_comb begin
    c_any  = 1'b0;
    ck_hit = '0;
    for (int k = CacheEntries - 1; k >= 0; k--) begin
      if (cv_q[k] && ck_q[k] == it_q.handle_id) begin
        c_any  = 1'b1;
        ck_hit = 3'(k);
      end
    end
  end

  assign q_pop_o        = (st_q == S_IDLE) && q_valid_i;
  assign done_o         = (st_q == S_DONE);
  assign status_o       = stat_q;
  assign new_id_o       = nid_q;
  assign found_object_o = fobj_q;
  assign cache_hit_o    = hit_q;

  // memory read ports, registered
  always_ff @(posedge clk_i) begin
    rhead_q <= head_mem[hidx_q];
    rid_q   <= eid_mem[cur_q[EW-1:0]];
    robj_q  <= eobj_mem[cur_q[EW-1:0]];
    rlink_q <= link_mem[cur_q[EW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_INIT;
      ctr_q  <= '0;
      free_q <= '0;
      stat_q <= '0;
      nid_q  <= '0;
      fobj_q <= '0;
      hit_q  <= 1'b0;
      for (int g = 0; g < NumGroups; g++) begin
        use_q[g] <= '0; seq_q[g] <= '0; mask_q[g] <= '0;
      end
      for (int k = 0; k < CacheEntries; k++) begin
        ck_q[k] <= '0; co_q[k] <= '0; cv_q[k] <= 1'b0;
      end
    end else begin
      case (st_q)
        // clear bucket heads and chain the free pool, one address a cycle
        S_INIT: begin
          head_mem[ctr_q[HW-1:0]] <= Nil;
          if (ctr_q < (HW+1)'(Capacity))
            link_mem[ctr_q[EW-1:0]] <= LW'(ctr_q) + LW'(1);
          ctr_q <= ctr_q + (HW+1)'(1);
          if (ctr_q == (HW+1)'(NumGroups*MaxBuckets-1)) st_q <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid_i) begin
            it_q   <= q_item_i;
            stat_q <= ST_OK; nid_q <= '0; fobj_q <= '0; hit_q <= 1'b0;
            st_q   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (it_q.kind)
            KIND_OPEN: begin
              st_q <= S_DONE;
              if (it_q.bucket_count == 16'd0 || (it_q.bucket_count & bcm1) != 16'd0
                  || it_q.bucket_count > 16'(MaxBuckets)) stat_q <= ST_BAD;
              else if (use_q[it_q.group] == 8'd255) stat_q <= ST_FULL;
              else begin
                use_q[it_q.group] <= use_q[it_q.group] + 8'd1;
                if (use_q[it_q.group] == 8'd0) begin
                  // buckets were left empty by the last drop or by reset
                  mask_q[it_q.group] <= bcm1[BW-1:0];
                  seq_q[it_q.group]  <= '0;
                end
              end
            end
            KIND_CLOSE: begin
              if (use_q[it_q.group] == 8'd0) begin
                stat_q <= ST_MISS;
                st_q   <= S_DONE;
              end else begin
                use_q[it_q.group] <= use_q[it_q.group] - 8'd1;
                if (use_q[it_q.group] == 8'd1) begin
                  for (int k = 0; k < CacheEntries; k++)
                    if (cv_q[k] && ck_q[k][31:28] == it_q.group) begin
                      cv_q[k] <= 1'b0; ck_q[k] <= '0; co_q[k] <= '0;
                    end
                  ctr_q   <= '0;
                  hidx_q  <= {it_q.group, BW'(0)};
                  steps_q <= '0;
                  st_q    <= S_DROPRD;
                end else begin
                  st_q <= S_DONE;
                end
              end
            end
            KIND_REG: begin
              if (use_q[it_q.group] == 8'd0) begin
                stat_q <= ST_MISS;
                st_q   <= S_DONE;
              end else if (free_q >= Nil) begin
                stat_q <= ST_FULL;
                st_q   <= S_DONE;
              end else begin
                hidx_q <= sidx;
                cur_q  <= free_q;
                st_q   <= S_HEADRD;
              end
            end
            KIND_LOOKUP, KIND_REMOVE: begin
              if (it_q.kind == KIND_LOOKUP && c_any) begin
                hit_q  <= 1'b1;
                fobj_q <= co_q[ck_hit[1:0]];
                st_q   <= S_DONE;
                if (ck_hit != 3'd0) begin
                  ck_q[ck_hit[1:0]-2'd1] <= ck_q[ck_hit[1:0]];
                  co_q[ck_hit[1:0]-2'd1] <= co_q[ck_hit[1:0]];
                  cv_q[ck_hit[1:0]-2'd1] <= cv_q[ck_hit[1:0]];
                  ck_q[ck_hit[1:0]] <= ck_q[ck_hit[1:0]-2'd1];
                  co_q[ck_hit[1:0]] <= co_q[ck_hit[1:0]-2'd1];
                  cv_q[ck_hit[1:0]] <= cv_q[ck_hit[1:0]-2'd1];
                end
              end else if (use_q[idg] == 8'd0) begin
                stat_q <= ST_MISS;
                st_q   <= S_DONE;
              end else begin
                hidx_q  <= {idg, it_q.handle_id[BW-1:0] & mask_q[idg]};
                prev_q  <= Nil;
                steps_q <= '0;
                st_q    <= S_HEADRD;
              end
            end
            default: begin
              stat_q <= ST_BAD;
              st_q   <= S_DONE;
            end
          endcase
        end
        S_HEADRD: st_q <= S_HEADWT;
        S_HEADWT: begin
          if (it_q.kind == KIND_REG) begin
            // free_q slot: read its link to pop the pool
            st_q <= S_REGWR;
          end else begin
            cur_q <= rhead_q;
            st_q  <= S_WALKRD;
          end
        end
        S_REGWR: begin
          free_q <= rlink_q;
          eid_mem[cur_q[EW-1:0]]  <= {it_q.group, seq_q[it_q.group]};
          eobj_mem[cur_q[EW-1:0]] <= it_q.object_value;
          link_mem[cur_q[EW-1:0]] <= rhead_q;
          head_mem[hidx_q]        <= cur_q;
          nid_q <= {it_q.group, seq_q[it_q.group]};
          seq_q[it_q.group] <= seq_q[it_q.group] + 28'd1;
          st_q <= S_DONE;
        end
        S_WALKRD: begin
          if (cur_q >= Nil || steps_q == (LW+1)'(Capacity)) begin
            stat_q <= ST_MISS;
            st_q   <= S_DONE;
          end else st_q <= S_WALKCMP;
        end
        S_WALKCMP: begin
          if (rid_q == it_q.handle_id) begin
            fobj_q <= robj_q;
            if (it_q.kind == KIND_LOOKUP) begin
              ck_q[CacheEntries-1] <= it_q.handle_id;
              co_q[CacheEntries-1] <= robj_q;
              cv_q[CacheEntries-1] <= 1'b1;
              st_q <= S_DONE;
            end else begin
              if (prev_q >= Nil) head_mem[hidx_q] <= rlink_q;
              else link_mem[prev_q[EW-1:0]] <= rlink_q;
              for (int k = 0; k < CacheEntries; k++)
                if (cv_q[k] && ck_q[k] == it_q.handle_id) begin
                  cv_q[k] <= 1'b0; ck_q[k] <= '0; co_q[k] <= '0;
                end
              st_q <= S_RMFREE;
            end
          end else begin
            prev_q  <= cur_q;
            cur_q   <= rlink_q;
            steps_q <= steps_q + (LW+1)'(1);
            st_q    <= S_WALKRD;
          end
        end
        // removed entry goes back on the free pool
        S_RMFREE: begin
          link_mem[cur_q[EW-1:0]] <= free_q;
          free_q <= cur_q;
          st_q   <= S_DONE;
        end
        // drop: free every chained entry of each bucket, clear the heads
        S_DROPRD: st_q <= S_DROPWT;
        S_DROPWT: begin
          cur_q <= rhead_q;
          head_mem[hidx_q] <= Nil;
          st_q <= S_DROPNX;
        end
        S_DROPNX: begin
          if (cur_q < Nil && steps_q != (LW+1)'(Capacity)) begin
            st_q <= S_DROPLK;    // link of cur_q is read at this edge
          end else if (ctr_q[BW-1:0] == mask_q[it_q.group] ||
                       ctr_q == (HW+1)'(MaxBuckets-1)) begin
            st_q <= S_DONE;
          end else begin
            ctr_q  <= ctr_q + (HW+1)'(1);
            hidx_q <= {it_q.group, BW'(ctr_q + (HW+1)'(1))};
            st_q   <= S_DROPRD;
          end
        end
        S_DROPLK: begin
          link_mem[cur_q[EW-1:0]] <= free_q;
          free_q  <= cur_q;
          cur_q   <= rlink_q;
          steps_q <= steps_q + (LW+1)'(1);
          st_q    <= S_DROPNX;
        end
        S_DONE: st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/handle_table_with_lookup_cache.sv]
// Top level of the handle table with its lookup cache.
//  channel | ports                                       | handshake
//  command | kind_i group_i bucket_count_i handle_id_i object_value_i | start_i, busy_o
//  result  | status_o new_id_o found_object_o cache_hit_o| done_o strobe, one cycle
// Open, plain close, cache hit or reject end at dispatch; register pops the free pool.
// Lookup on an open group compares each chain entry in turn; remove then frees it.
// Close at zero walks every bucket of the group, freeing each entry and clearing heads.
// After reset a clearing pass runs over all 1024 bucket heads; busy fills then.
// A two-item queue takes commands while the sequencer works; results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module handle_table_with_lookup_cache (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        start_i,
  output logic              busy_o,
  input  wire  logic [2:0]  kind_i,
  input  wire  logic [3:0]  group_i,
  input  wire  logic [15:0] bucket_count_i,
  input  wire  logic [31:0] handle_id_i,
  input  wire  logic [31:0] object_value_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [31:0]       new_id_o,
  output logic [31:0]       found_object_o,
  output logic              cache_hit_o
);
  import htlc_pkg::*;
  item_t in_item, q_item;
  logic q_valid, q_pop;

  assign in_item = '{kind: kind_i, group: group_i, bucket_count: bucket_count_i,
                     handle_id: handle_id_i, object_value: object_value_i};

  htlc_front u_front (
    .clk_i, .rst_ni, .start_i, .item_i(in_item), .busy_o,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  htlc_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .done_o, .status_o, .new_id_o, .found_object_o, .cache_hit_o
  );

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && cache_hit_o |-> status_o == ST_OK && new_id_o == 32'd0)
    else $error("cache hit with bad status");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
endmodule
`default_nettype wire
